FILE: design/gdr_pkg.sv
// Shared types, constants and arithmetic helpers for the grid DDA ray caster.
// Depends on nothing; every module of the block imports it.
package gdr_pkg;

    localparam int MAP_DIM    = 64;
    localparam int ANGLE_BITS = 12;
    localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
    localparam int SINE_SHIFT = 17 - ANGLE_BITS;
    localparam int CELL_BITS  = 6;
    localparam int MAP_BITS   = 2 * CELL_BITS;
    localparam int POS_BITS   = 14;
    localparam int DIST_BITS  = 24;
    localparam logic [DIST_BITS-1:0] DIST_INF = 24'hFF_FFFF;
    localparam logic [7:0] STEP_LIMIT_RST = 8'd128;
    localparam int QDEPTH = 2;

    typedef enum logic {OP_WRITE = 1'b0, OP_CAST = 1'b1} t_op;

    typedef struct packed {
        t_op                 op;
        logic [5:0]          col;
        logic [5:0]          row;
        logic                wall;
        logic [POS_BITS-1:0] vx;
        logic [POS_BITS-1:0] vy;
        logic [11:0]         angle;
    } t_item;

    typedef struct packed {
        logic [15:0]         ray_dist;
        logic                vert;
        logic [POS_BITS-1:0] hx;
        logic [POS_BITS-1:0] hy;
        logic [5:0]          col;
        logic [5:0]          row;
        logic                gave_up;
    } t_result;

    // Quarter-wave sine in Q15 in, Q14 out.
    function automatic logic [14:0] quarter_sine(input logic [15:0] x);
        logic [31:0] x2;
        logic [47:0] t;
        x2 = ({16'd0, x} * {16'd0, x}) >> 15;
        t  = (48'd2611 * {16'd0, x2}) >> 15;
        t  = 48'd21167 - t;
        t  = (t * {16'd0, x2}) >> 15;
        t  = 48'd51472 - t;
        t  = (t * {32'd0, x}) >> 15;
        if (t > 48'd32768) t = 48'd32768;
        quarter_sine = 15'((t + 48'd1) >> 1);
    endfunction

endpackage

FILE: design/grid_dda_ray_caster.sv
// Top level of the grid DDA ray caster: APB register, front end and back end.
// Depends on gdr_pkg, gdr_front and gdr_back.
//
// Usage: offer a request with start; it is taken at an edge where busy is low.
// A write request (op 0) sets one map cell and yields no result; it is held
// off while any cast is queued or being walked, so map edits land in request
// order. A cast request (op 1) joins a two-entry queue; its result is on the
// o_ ports for one cycle with o_result_valid and the receiver cannot stall it.
// A cast that finds the back end idle is popped from the queue, reads the
// sine table, runs two reciprocal divisions and forms the side distances,
// then walks the grid, with one step and one map read per grid step.
// The back end works on one cast at a time and pops the next only once it
// is idle again; the divider is shared and the map has a single read port.
// After reset the map is cleared, one cell a cycle, with busy high, and
// step_limit returns to 128. Write step_limit through the APB port only
// while no cast is queued or in flight.
module grid_dda_ray_caster
    import gdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [5:0]  i_cell_col,
    input  logic [5:0]  i_cell_row,
    input  logic        i_cell_is_wall,
    input  logic [13:0] i_view_x,
    input  logic [13:0] i_view_y,
    input  logic [11:0] i_ray_angle,
    output logic        o_result_valid,
    output logic [15:0] o_ray_distance,
    output logic        o_face_vertical,
    output logic [13:0] o_hit_x,
    output logic [13:0] o_hit_y,
    output logic [5:0]  o_hit_col,
    output logic [5:0]  o_hit_row,
    output logic        o_gave_up
);
    logic [7:0] r_step_limit;
    t_item item, head;
    t_result res;
    logic full, avail, pop, idle, wr_en, wr_data, take;
    logic [MAP_BITS-1:0] wr_addr;
    logic clearing, r_seen_idle;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {24'd0, r_step_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_step_limit <= STEP_LIMIT_RST;
        else if (psel && penable && pwrite && paddr == 2'd0) r_step_limit <= pwdata[7:0];
    end

    // Requests wait for the clearing sweep, which holds the back end out of idle.
    // A write also waits until every earlier cast has finished its walk.
    assign busy = full || clearing || (i_op == OP_WRITE && (avail || !idle));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seen_idle <= 1'b0;
        else if (idle) r_seen_idle <= 1'b1;
    end
    assign clearing = !r_seen_idle;
    assign take = start && !busy;

    assign item = '{op: t_op'(i_op), col: i_cell_col, row: i_cell_row, wall: i_cell_is_wall,
                    vx: i_view_x, vy: i_view_y, angle: i_ray_angle};

    gdr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_item(item), .i_pop(pop),
        .o_full(full), .o_avail(avail), .o_head(head),
        .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_wr_data(wr_data)
    );

    gdr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step_limit(r_step_limit),
        .i_avail(avail), .i_head(head), .o_pop(pop), .o_idle(idle),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .o_res_valid(o_result_valid), .o_res(res)
    );

    assign o_ray_distance  = res.ray_dist;
    assign o_face_vertical = res.vert;
    assign o_hit_x         = res.hx;
    assign o_hit_y         = res.hy;
    assign o_hit_col       = res.col;
    assign o_hit_row       = res.row;
    assign o_gave_up       = res.gave_up;
endmodule

FILE: design/gdr_front.sv
// Front end: takes start requests, writes map cells, and queues cast requests.
// Depends on gdr_pkg. The wall map memory lives in gdr_back.
module gdr_front
    import gdr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_avail,
    output t_item o_head,
    output logic  o_wr_en,
    output logic [MAP_BITS-1:0] o_wr_addr,
    output logic  o_wr_data
);
    t_item r_q [QDEPTH];
    logic [0:0] r_rd, r_wr;
    logic [1:0] r_cnt;
    logic push;

    assign push      = i_take && (i_item.op == OP_CAST);
    assign o_wr_en   = i_take && (i_item.op == OP_WRITE);
    assign o_wr_addr = {i_item.row, i_item.col};
    assign o_wr_data = i_item.wall;
    assign o_full    = (r_cnt == 2'(QDEPTH));
    assign o_avail   = (r_cnt != 2'd0);
    assign o_head    = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_item;
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !push) else $error("cast queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail) else $error("cast queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH)) else $error("queue count out of range");
endmodule

FILE: design/gdr_back.sv
// Back end: wall map memory with clear sweep, sine table, and the cast sequencer
// that sets up direction and reciprocals and walks the grid. Depends on gdr_pkg.
module gdr_back
    import gdr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic [7:0] i_step_limit,
    input  logic  i_avail,
    input  t_item i_head,
    output logic  o_pop,
    output logic  o_idle,
    input  logic  i_wr_en,
    input  logic [MAP_BITS-1:0] i_wr_addr,
    input  logic  i_wr_data,
    output logic  o_res_valid,
    output t_result o_res
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001, S_IDLE = 8'b0000_0010, S_DIR   = 8'b0000_0100,
        S_DIVX  = 8'b0000_1000, S_DIVY = 8'b0001_0000, S_SIDE  = 8'b0010_0000,
        S_STEP  = 8'b0100_0000, S_CHECK = 8'b1000_0000
    } t_state;

    t_state r_st;
    logic r_map [MAP_DIM*MAP_DIM];
    logic r_rdata;
    logic [MAP_BITS:0] r_clr;
    logic [14:0] sine_tab [QUARTER+1];
    logic [14:0] r_sin, r_cos;
    logic [1:0] r_quad;

    logic [POS_BITS-1:0] r_px, r_py;
    logic [14:0] r_dx, r_dy;
    logic r_nx, r_ny;
    logic [DIST_BITS-1:0] r_ddx, r_ddy, r_sdx, r_sdy, r_dist;
    logic signed [8:0] r_cx, r_cy;
    logic r_vert;
    logic [7:0] r_n, r_lim;
    // Restoring divider for 2^22 / d.
    logic [22:0] r_quo;
    logic [15:0] r_rem;
    logic [4:0]  r_dcnt;
    logic r_div_done;

    logic out_map, step_x, walk_end;
    logic signed [8:0] n_cx, n_cy;
    logic [MAP_BITS-1:0] rd_addr;
    logic [16:0] rem_sh;
    logic [14:0] dir_x, dir_y;
    logic neg_x, neg_y;

    assign out_map = (r_cx < 0) || (r_cy < 0) || (r_cx >= MAP_DIM) || (r_cy >= MAP_DIM);
    assign step_x  = (r_sdx < r_sdy);
    assign n_cx    = step_x ? (r_nx ? r_cx - 9'sd1 : r_cx + 9'sd1) : r_cx;
    assign n_cy    = step_x ? r_cy : (r_ny ? r_cy - 9'sd1 : r_cy + 9'sd1);
    // The map is read at the cell that the current step enters.
    assign rd_addr = {n_cy[CELL_BITS-1:0], n_cx[CELL_BITS-1:0]};
    assign walk_end = out_map || r_rdata || (r_n == r_lim);
    assign o_idle  = (r_st == S_IDLE);
    assign o_pop   = (r_st == S_IDLE) && i_avail;

    always_ff @(posedge i_clk) begin
        if (r_st == S_CLEAR) r_map[r_clr[MAP_BITS-1:0]] <= 1'b0;
        else if (i_wr_en) r_map[i_wr_addr] <= i_wr_data;
        r_rdata <= r_map[rd_addr];
    end

    // The table spans a quarter turn and its end point, so the cosine of a is
    // the entry at QUARTER - a.
    initial begin
        for (int k = 0; k <= QUARTER; k++) sine_tab[k] = quarter_sine(16'(k << SINE_SHIFT));
    end

    logic [ANGLE_BITS-3:0] sa_idx;
    logic [ANGLE_BITS-2:0] cos_idx;
    assign sa_idx  = i_head.angle[ANGLE_BITS-3:0];
    assign cos_idx = (ANGLE_BITS-1)'(QUARTER) - {1'b0, sa_idx};

    always_ff @(posedge i_clk) begin
        r_sin <= sine_tab[{1'b0, sa_idx}];
        r_cos <= sine_tab[cos_idx];
    end

    always_comb begin
        unique case (r_quad)
            2'd0: begin dir_y = r_sin; neg_y = 1'b0; dir_x = r_cos; neg_x = 1'b0; end
            2'd1: begin dir_y = r_cos; neg_y = 1'b0; dir_x = r_sin; neg_x = 1'b1; end
            2'd2: begin dir_y = r_sin; neg_y = 1'b1; dir_x = r_cos; neg_x = 1'b1; end
            default: begin dir_y = r_cos; neg_y = 1'b1; dir_x = r_sin; neg_x = 1'b0; end
        endcase
    end

    function automatic logic [DIST_BITS-1:0] sat_add(input logic [DIST_BITS-1:0] a,
                                                     input logic [DIST_BITS-1:0] b);
        logic [DIST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[DIST_BITS] ? DIST_INF : s[DIST_BITS-1:0];
    endfunction

    function automatic logic [POS_BITS-1:0] hit_coord(input logic [POS_BITS-1:0] p,
            input logic neg, input logic [14:0] d, input logic [DIST_BITS-1:0] walked);
        logic [39:0] prod;
        logic signed [27:0] v;
        prod = {16'd0, walked} * {25'd0, d};
        v = 28'(signed'({1'b0, (prod + 40'd8192) >> 14}));
        v = neg ? 28'(p) - v : 28'(p) + v;
        if (v < 0) v = 0;
        if (v > 28'sd16383) v = 28'sd16383;
        hit_coord = v[POS_BITS-1:0];
    endfunction

    logic [14:0] d_sel;
    logic [8:0] fx_span, fy_span;
    logic [32:0] sdx_p, sdy_p;
    assign d_sel = (r_st == S_DIVX) ? r_dx : r_dy;
    assign rem_sh = {r_rem, r_quo[22]};
    assign fx_span = r_nx ? {1'b0, r_px[7:0]} : 9'd256 - {1'b0, r_px[7:0]};
    assign fy_span = r_ny ? {1'b0, r_py[7:0]} : 9'd256 - {1'b0, r_py[7:0]};
    assign sdx_p = {24'd0, fx_span} * {9'd0, r_ddx};
    assign sdy_p = {24'd0, fy_span} * {9'd0, r_ddy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR;
            r_clr <= '0;
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= (r_st == S_CHECK) && walk_end;
            unique case (r_st)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (MAP_BITS+1)'(MAP_DIM*MAP_DIM-1)) r_st <= S_IDLE;
                end
                S_IDLE: if (i_avail) begin
                    r_px <= i_head.vx;
                    r_py <= i_head.vy;
                    r_cx <= 9'(i_head.vx[POS_BITS-1:8]);
                    r_cy <= 9'(i_head.vy[POS_BITS-1:8]);
                    r_lim <= (i_step_limit == 8'd0) ? 8'd1 : i_step_limit;
                    r_quad <= i_head.angle[ANGLE_BITS-1 -: 2];
                    r_st <= S_DIR;
                end
                S_DIR: begin
                    // A zero component always steps in the positive direction.
                    r_dx <= dir_x;
                    r_dy <= dir_y;
                    r_nx <= neg_x && (dir_x != '0);
                    r_ny <= neg_y && (dir_y != '0);
                    r_quo <= 23'h40_0000; r_rem <= '0; r_dcnt <= '0; r_div_done <= 1'b0;
                    r_st <= S_DIVX;
                end
                S_DIVX, S_DIVY: begin
                    if (!r_div_done) begin
                        if (rem_sh >= {2'b0, d_sel}) begin
                            r_rem <= 16'(rem_sh - {2'b0, d_sel});
                            r_quo <= {r_quo[21:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[15:0];
                            r_quo <= {r_quo[21:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt + 1'b1;
                        if (r_dcnt == 5'd22) r_div_done <= 1'b1;
                    end else begin
                        r_quo <= 23'h40_0000; r_rem <= '0; r_dcnt <= '0; r_div_done <= 1'b0;
                        if (r_st == S_DIVX) begin
                            r_ddx <= (r_dx == '0) ? DIST_INF : 24'(r_quo);
                            r_st <= S_DIVY;
                        end else begin
                            r_ddy <= (r_dy == '0) ? DIST_INF : 24'(r_quo);
                            r_st <= S_SIDE;
                        end
                    end
                end
                S_SIDE: begin
                    r_sdx <= (r_dx == '0) ? DIST_INF : 24'(sdx_p >> 8);
                    r_sdy <= (r_dy == '0) ? DIST_INF : 24'(sdy_p >> 8);
                    r_n <= '0;
                    r_st <= S_STEP;
                end
                S_STEP: begin
                    if (step_x) begin
                        r_dist <= r_sdx; r_sdx <= sat_add(r_sdx, r_ddx); r_vert <= 1'b1;
                    end else begin
                        r_dist <= r_sdy; r_sdy <= sat_add(r_sdy, r_ddy); r_vert <= 1'b0;
                    end
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_n <= r_n + 1'b1;
                    r_st <= S_CHECK;
                end
                S_CHECK: begin
                    // The map bit of the entered cell was registered at the end of the step.
                    if (walk_end) begin
                        o_res.ray_dist <= (r_dist > 24'd65535) ? 16'hFFFF : r_dist[15:0];
                        o_res.vert  <= r_vert;
                        o_res.hx    <= hit_coord(r_px, r_nx, r_dx, r_dist);
                        o_res.hy    <= hit_coord(r_py, r_ny, r_dy, r_dist);
                        o_res.col   <= r_cx[5:0];
                        o_res.row   <= r_cy[5:0];
                        o_res.gave_up <= !(out_map || r_rdata);
                        r_st <= S_IDLE;
                    end else begin
                        r_st <= S_STEP;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_st == S_DIR)) else $error("pop outside idle");
    a_res_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(r_st == S_CHECK)) else $error("stray result");
    a_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CHECK) |-> (r_n <= r_lim)) else $error("step count overrun");
endmodule
